### src/spg_pkg.sv
// Shared types, constants and helpers for the scan-plane pose geometry block.
package spg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // unit vector path sizing
  localparam int QB        = FRAC_BITS + 1;     // quotient bits of a unit component
  localparam int DW        = 32 + QB;           // divider remainder width
  localparam int DIV_STG   = (QB + 1) / 2;      // two quotient bits per stage
  localparam int SQRT_STG  = 16;                // two root bits per stage
  localparam int LAT_U     = 8 + SQRT_STG + DIV_STG;
  localparam int LAT       = 10 + LAT_U;        // stages ahead of the output buffer
  localparam int GEO_DLY   = 6 + LAT_U;

  localparam logic signed [71:0] WHI = (72'sd1 <<< (WORD_BITS - 1)) - 72'sd1;
  localparam logic signed [71:0] WLO = -WHI - 72'sd1;

  localparam logic [2:0] REG_C00_C01 = 3'd0;
  localparam logic [2:0] REG_C02_C10 = 3'd1;
  localparam logic [2:0] REG_C11_C12 = 3'd2;
  localparam logic [2:0] REG_C20_C21 = 3'd3;
  localparam logic [2:0] REG_C22_EXX = 3'd4;
  localparam logic [2:0] REG_EXY_ORX = 3'd5;
  localparam logic [2:0] REG_ORY_ORZ = 3'd6;

  localparam logic [2:0] KIND_CORNER0 = 3'd0;
  localparam logic [2:0] KIND_CORNERX = 3'd1;
  localparam logic [2:0] KIND_CORNERY = 3'd2;
  localparam logic [2:0] KIND_PLANE   = 3'd3;
  localparam logic [2:0] KIND_XUNIT   = 3'd4;
  localparam logic [2:0] KIND_YUNIT   = 3'd5;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t      val;
    logic       clip;
  } sat_t;

  typedef struct packed {
    word_t [2:0] c0;
    word_t [2:0] c1;
    word_t [2:0] c2;
    logic        msat;
    logic [2:0]  csat;
  } geo_t;

  typedef struct packed {
    word_t [2:0] n;
    logic        deg;
    logic        sat;
  } ures_t;

  typedef struct packed {
    logic [2:0] kind;
    word_t      x;
    word_t      y;
    word_t      z;
    word_t      w;
    logic       deg;
    logic       sat;
  } vec_t;

  function automatic sat_t sat_w(input logic signed [71:0] v);
    sat_t r;
    if (v > WHI) begin
      r.val  = WHI[31:0];
      r.clip = 1'b1;
    end else if (v < WLO) begin
      r.val  = WLO[31:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

### src/spg_xform.sv
// Calibration times pose, then the three image corners relative to the volume origin.
module spg_xform (
  input  logic                  clk,
  input  logic                  en,
  input  spg_pkg::word_t [11:0] pose,
  input  spg_pkg::word_t [8:0]  cal,
  input  spg_pkg::word_t        ext_x,
  input  spg_pkg::word_t        ext_y,
  input  spg_pkg::word_t [2:0]  org,
  output spg_pkg::geo_t         geo
);

  logic signed [63:0] prod [3][4][3];
  spg_pkg::word_t     m [3][4];
  spg_pkg::word_t     m_next [3][4];
  logic               msat, msat_next, msat3;
  logic signed [63:0] pcx [3];
  logic signed [63:0] pcy [3];
  logic signed [32:0] tr [3];
  spg_pkg::geo_t      geo_next;

  always_comb begin
    logic signed [65:0] s;
    spg_pkg::sat_t r;
    msat_next = 1'b0;
    for (int b = 0; b < 3; b++) begin
      for (int c = 0; c < 4; c++) begin
        s = 66'(prod[b][c][0]) + 66'(prod[b][c][1]) + 66'(prod[b][c][2]);
        r = spg_pkg::sat_w(72'(s >>> spg_pkg::FRAC_BITS));
        m_next[b][c] = r.val;
        msat_next = msat_next | r.clip;
      end
    end
  end

  always_comb begin
    spg_pkg::sat_t r0, r1, r2;
    geo_next.msat = msat3;
    geo_next.csat = 3'b000;
    for (int i = 0; i < 3; i++) begin
      r0 = spg_pkg::sat_w(72'(tr[i]));
      r1 = spg_pkg::sat_w(72'(pcx[i] >>> spg_pkg::FRAC_BITS) + 72'(tr[i]));
      r2 = spg_pkg::sat_w(72'(pcy[i] >>> spg_pkg::FRAC_BITS) + 72'(tr[i]));
      geo_next.c0[i] = r0.val;
      geo_next.c1[i] = r1.val;
      geo_next.c2[i] = r2.val;
      geo_next.csat[0] = geo_next.csat[0] | r0.clip;
      geo_next.csat[1] = geo_next.csat[1] | r1.clip;
      geo_next.csat[2] = geo_next.csat[2] | r2.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 3; k++) begin
            prod[b][c][k] <= $signed(cal[b*3+k]) * $signed(pose[k*4+c]);
          end
        end
      end
      m    <= m_next;
      msat <= msat_next;
      for (int i = 0; i < 3; i++) begin
        pcx[i] <= $signed(m[i][1]) * $signed(ext_x);
        pcy[i] <= $signed(m[i][2]) * $signed(ext_y);
        tr[i]  <= 33'($signed(m[i][3])) - 33'($signed(org[i]));
      end
      msat3 <= msat;
      geo   <= geo_next;
    end
  end

endmodule

### src/spg_unit.sv
// Pipelined unit-vector unit: normalize, sum of squares, square root, rounded divide.
module spg_unit (
  input  logic             clk,
  input  logic             en,
  input  logic [2:0][62:0] vin,
  output spg_pkg::ures_t   res
);

  typedef struct packed {
    logic [2:0][62:0] c;
    logic [61:0]      orm;
  } nrm_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][30:0] wm;
    logic             zero;
  } car_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sqs_t;

  typedef struct packed {
    logic [spg_pkg::DW-1:0] r;
    logic [spg_pkg::QB-1:0] q;
  } div_t;

  function automatic nrm_t nstep(input nrm_t x, input int k);
    nrm_t y;
    y = x;
    if ((x.orm >> (62 - k)) == 62'd0) begin
      for (int i = 0; i < 3; i++) y.c[i] = x.c[i] << k;
      y.orm = x.orm << k;
    end
    return y;
  endfunction

  function automatic sqs_t rstep(input sqs_t x, input int j);
    sqs_t        y;
    logic [63:0] b;
    y = x;
    b = 64'd1 << (62 - 2 * j);
    if (y.v >= y.r + b) begin
      y.v = y.v - (y.r + b);
      y.r = (y.r >> 1) + b;
    end else begin
      y.r = y.r >> 1;
    end
    return y;
  endfunction

  function automatic div_t dstep(input div_t x, input logic [31:0] d, input int b);
    div_t                   y;
    logic [spg_pkg::DW-1:0] ds;
    y = x;
    if (b >= 0) begin
      ds = spg_pkg::DW'(d) << b;
      if (y.r >= ds) begin
        y.r    = y.r - ds;
        y.q[b] = 1'b1;
      end
    end
    return y;
  endfunction

  nrm_t        nr [0:3];
  nrm_t        nr0_next;
  logic        zero_a;
  logic [61:0] sqr [3];
  car_t        car_q, car_s;
  logic [63:0] sq_sum;
  sqs_t        rs0;
  sqs_t        rs [1:spg_pkg::SQRT_STG];
  car_t        car_r [1:spg_pkg::SQRT_STG];
  div_t        dv [0:spg_pkg::DIV_STG][3];
  logic [31:0] dd [0:spg_pkg::DIV_STG];
  car_t        car_d [0:spg_pkg::DIV_STG];
  car_t        car_q_next;
  logic        zero_n [1:3];

  always_comb begin
    logic [62:0] mg;
    nr0_next.orm = '0;
    for (int i = 0; i < 3; i++) begin
      mg = vin[i][62] ? 63'(-$signed(vin[i])) : vin[i];
      nr0_next.c[i] = vin[i];
      nr0_next.orm  = nr0_next.orm | mg[61:0];
    end
  end

  always_comb begin
    logic signed [30:0] w;
    car_q_next.zero = zero_n[3];
    for (int i = 0; i < 3; i++) begin
      w = nr[3].c[i][62:32];
      car_q_next.neg[i] = w[30];
      car_q_next.wm[i]  = w[30] ? 31'(-w) : w;
    end
  end

  assign rs0 = '{v: sq_sum, r: 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      nr[0]  <= nr0_next;
      zero_a <= (nr0_next.orm == 62'd0);
      nr[1]  <= nstep(nstep(nr[0], 32), 16);
      nr[2]  <= nstep(nstep(nr[1], 8), 4);
      nr[3]  <= nstep(nstep(nr[2], 2), 1);
      zero_n[1] <= zero_a;
      zero_n[2] <= zero_n[1];
      zero_n[3] <= zero_n[2];

      car_q <= car_q_next;
      for (int i = 0; i < 3; i++) begin
        sqr[i] <= 62'(car_q_next.wm[i]) * 62'(car_q_next.wm[i]);
      end
      sq_sum <= 64'(sqr[0]) + 64'(sqr[1]) + 64'(sqr[2]);
      car_s  <= car_q;

      rs[1]    <= rstep(rstep(rs0, 0), 1);
      car_r[1] <= car_s;
      for (int t = 2; t <= spg_pkg::SQRT_STG; t++) begin
        rs[t]    <= rstep(rstep(rs[t-1], 2 * t - 2), 2 * t - 1);
        car_r[t] <= car_r[t-1];
      end

      // round to nearest: (|w| * 2^(F+1) + len) / (2 * len)
      dd[0]    <= {rs[spg_pkg::SQRT_STG].r[30:0], 1'b0};
      car_d[0] <= car_r[spg_pkg::SQRT_STG];
      for (int i = 0; i < 3; i++) begin
        dv[0][i].r <= (spg_pkg::DW'(car_r[spg_pkg::SQRT_STG].wm[i]) << (spg_pkg::FRAC_BITS + 1))
                    + spg_pkg::DW'(rs[spg_pkg::SQRT_STG].r[30:0]);
        dv[0][i].q <= '0;
      end
      for (int t = 1; t <= spg_pkg::DIV_STG; t++) begin
        dd[t]    <= dd[t-1];
        car_d[t] <= car_d[t-1];
        for (int i = 0; i < 3; i++) begin
          dv[t][i] <= dstep(dstep(dv[t-1][i], dd[t-1], spg_pkg::QB + 1 - 2 * t),
                            dd[t-1], spg_pkg::QB - 2 * t);
        end
      end

      begin : fin
        logic signed [71:0] sv;
        spg_pkg::sat_t      r;
        logic               any;
        any = 1'b0;
        for (int i = 0; i < 3; i++) begin
          sv = 72'($signed({1'b0, dv[spg_pkg::DIV_STG][i].q}));
          if (car_d[spg_pkg::DIV_STG].neg[i]) sv = -sv;
          r = spg_pkg::sat_w(sv);
          res.n[i] <= car_d[spg_pkg::DIV_STG].zero ? 32'd0 : r.val;
          any = any | r.clip;
        end
        res.deg <= car_d[spg_pkg::DIV_STG].zero;
        res.sat <= any & ~car_d[spg_pkg::DIV_STG].zero;
      end
    end
  end

endmodule

### src/spg_serial.sv
// Output buffer that hands out the six vectors of one pose in order.
module spg_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  input  spg_pkg::vec_t [5:0] vecs,
  input  logic                out_stall,
  output logic                ready,
  output logic                out_valid,
  output spg_pkg::vec_t       head
);

  logic                busy;
  logic                done;
  spg_pkg::vec_t [5:0] slots;

  assign head      = slots[0];
  assign out_valid = busy;
  assign done      = busy && !out_stall && (slots[0].kind == spg_pkg::KIND_YUNIT);
  assign ready     = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load_valid && ready) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && ready) begin
      slots <= vecs;
    end else if (busy && !out_stall) begin
      slots <= {slots[5], slots[5:1]};
    end
  end

endmodule

### src/scan_plane_pose_geometry.sv
// Scan-plane pose geometry: top level with edge, cross product and plane stages.
// Path: transform, edge, cross product, unit-vector and plane offset stages,
//   then the output buffer; LAT_U is set by the square root and divider stages.
// Output: the buffer holds one pose and takes the next as its last vector leaves;
//   the pipeline takes a pose in any cycle while its last stage can move on.
// Reset: clears all stage valid bits and the output buffer, loads an identity
//   calibration with zero extents and origin.
module scan_plane_pose_geometry (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] pose_00,
  input  logic [31:0] pose_01,
  input  logic [31:0] pose_02,
  input  logic [31:0] pose_03,
  input  logic [31:0] pose_10,
  input  logic [31:0] pose_11,
  input  logic [31:0] pose_12,
  input  logic [31:0] pose_13,
  input  logic [31:0] pose_20,
  input  logic [31:0] pose_21,
  input  logic [31:0] pose_22,
  input  logic [31:0] pose_23,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  vector_kind,
  output logic [31:0] comp_x,
  output logic [31:0] comp_y,
  output logic [31:0] comp_z,
  output logic [31:0] comp_w,
  output logic        degenerate,
  output logic        saturated,
  output logic        last
);

  logic [63:0] regs [7];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'h0001_0000_0000_0000;
      regs[1] <= 64'd0;
      regs[2] <= 64'h0001_0000_0000_0000;
      regs[3] <= 64'd0;
      regs[4] <= 64'h0001_0000_0000_0000;
      regs[5] <= 64'd0;
      regs[6] <= 64'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spg_pkg::REG_C00_C01: regs[0] <= cfg_data;
        spg_pkg::REG_C02_C10: regs[1] <= cfg_data;
        spg_pkg::REG_C11_C12: regs[2] <= cfg_data;
        spg_pkg::REG_C20_C21: regs[3] <= cfg_data;
        spg_pkg::REG_C22_EXX: regs[4] <= cfg_data;
        spg_pkg::REG_EXY_ORX: regs[5] <= cfg_data;
        spg_pkg::REG_ORY_ORZ: regs[6] <= cfg_data;
        default: ;
      endcase
    end
  end

  spg_pkg::word_t [8:0]  cal;
  spg_pkg::word_t [2:0]  org;
  spg_pkg::word_t [11:0] pose;

  assign cal  = {regs[4][63:32], regs[3][31:0], regs[3][63:32], regs[2][31:0],
                 regs[2][63:32], regs[1][31:0], regs[1][63:32], regs[0][31:0],
                 regs[0][63:32]};
  assign org  = {regs[6][31:0], regs[6][63:32], regs[5][31:0]};
  assign pose = {pose_23, pose_22, pose_21, pose_20, pose_13, pose_12, pose_11, pose_10,
                 pose_03, pose_02, pose_01, pose_00};

  // stage valid bits; the whole line moves together
  logic [spg_pkg::LAT-1:0] vld;
  logic                    en;
  logic                    ld_ok;

  assign en       = !vld[spg_pkg::LAT-1] || ld_ok;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[spg_pkg::LAT-2:0], in_valid};
    end
  end

  spg_pkg::geo_t geo;

  spg_xform u_xform (
    .clk   (clk),
    .en    (en),
    .pose  (pose),
    .cal   (cal),
    .ext_x (regs[4][31:0]),
    .ext_y (regs[5][63:32]),
    .org   (org),
    .geo   (geo)
  );

  spg_pkg::geo_t geo_pipe [spg_pkg::GEO_DLY];

  logic signed [32:0] su [3];
  logic signed [32:0] sv [3];
  logic signed [32:0] e1 [3];
  logic signed [30:0] us [3];
  logic signed [30:0] vs [3];
  logic signed [32:0] e1_6 [3];
  logic signed [32:0] e2_6 [3];
  logic signed [61:0] xp [6];
  logic signed [32:0] e1_7 [3];
  logic signed [32:0] e2_7 [3];
  logic signed [62:0] cr [3];
  logic signed [32:0] e1_8 [3];
  logic signed [32:0] e2_8 [3];
  logic [1:0]         sh;

  always_comb begin
    logic [32:0] mu, mv;
    logic [31:0] orv;
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      mu  = su[i][32] ? 33'(-su[i]) : su[i];
      mv  = sv[i][32] ? 33'(-sv[i]) : sv[i];
      orv = orv | mu[31:0] | mv[31:0];
    end
    // bring every component of both edges into the 31-bit signed range before the cross product
    if (orv[31]) sh = 2'd2;
    else if (orv[30]) sh = 2'd1;
    else sh = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_pipe[0] <= geo;
      for (int k = 1; k < spg_pkg::GEO_DLY; k++) geo_pipe[k] <= geo_pipe[k-1];
      for (int i = 0; i < 3; i++) begin
        su[i]   <= 33'($signed(geo.c0[i])) - 33'($signed(geo.c1[i]));
        sv[i]   <= 33'($signed(geo.c2[i])) - 33'($signed(geo.c0[i]));
        e1[i]   <= 33'($signed(geo.c1[i])) - 33'($signed(geo.c0[i]));
        us[i]   <= 31'(su[i] >>> sh);
        vs[i]   <= 31'(sv[i] >>> sh);
        e1_6[i] <= e1[i];
        e2_6[i] <= sv[i];
        e1_7[i] <= e1_6[i];
        e2_7[i] <= e2_6[i];
        e1_8[i] <= e1_7[i];
        e2_8[i] <= e2_7[i];
      end
      xp[0] <= us[1] * vs[2];
      xp[1] <= us[2] * vs[1];
      xp[2] <= us[2] * vs[0];
      xp[3] <= us[0] * vs[2];
      xp[4] <= us[0] * vs[1];
      xp[5] <= us[1] * vs[0];
      cr[0] <= 63'(xp[0]) - 63'(xp[1]);
      cr[1] <= 63'(xp[2]) - 63'(xp[3]);
      cr[2] <= 63'(xp[4]) - 63'(xp[5]);
    end
  end

  logic [2:0][62:0] uin_p, uin_x, uin_y;
  spg_pkg::ures_t   ur_p, ur_x, ur_y;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uin_p[i] = cr[i];
      uin_x[i] = 63'(e1_8[i]);
      uin_y[i] = 63'(e2_8[i]);
    end
  end

  spg_unit u_unit_p (.clk(clk), .en(en), .vin(uin_p), .res(ur_p));
  spg_unit u_unit_x (.clk(clk), .en(en), .vin(uin_x), .res(ur_x));
  spg_unit u_unit_y (.clk(clk), .en(en), .vin(uin_y), .res(ur_y));

  // plane offset: -(n . corner0)
  logic signed [63:0] pp [3];
  spg_pkg::ures_t     up1, ux1, uy1, up2, ux2, uy2;
  spg_pkg::word_t     off_w;
  logic               off_clip;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp[i] <= $signed(ur_p.n[i]) * $signed(geo_pipe[spg_pkg::LAT_U + 3].c0[i]);
      end
      up1 <= ur_p;
      ux1 <= ur_x;
      uy1 <= ur_y;
      begin : offs
        logic signed [66:0] so;
        spg_pkg::sat_t      r;
        so = -(67'(pp[0]) + 67'(pp[1]) + 67'(pp[2]));
        r  = spg_pkg::sat_w(72'(so >>> spg_pkg::FRAC_BITS));
        off_w    <= r.val;
        off_clip <= r.clip;
      end
      up2 <= up1;
      ux2 <= ux1;
      uy2 <= uy1;
    end
  end

  spg_pkg::geo_t       gf;
  spg_pkg::vec_t [5:0] vecs;
  spg_pkg::vec_t       head;
  logic                anyc;

  assign gf   = geo_pipe[spg_pkg::GEO_DLY-1];
  assign anyc = gf.msat | (|gf.csat);

  always_comb begin
    vecs[0] = '{kind: spg_pkg::KIND_CORNER0, x: gf.c0[0], y: gf.c0[1], z: gf.c0[2],
                w: 32'd0, deg: 1'b0, sat: gf.msat | gf.csat[0]};
    vecs[1] = '{kind: spg_pkg::KIND_CORNERX, x: gf.c1[0], y: gf.c1[1], z: gf.c1[2],
                w: 32'd0, deg: 1'b0, sat: gf.msat | gf.csat[1]};
    vecs[2] = '{kind: spg_pkg::KIND_CORNERY, x: gf.c2[0], y: gf.c2[1], z: gf.c2[2],
                w: 32'd0, deg: 1'b0, sat: gf.msat | gf.csat[2]};
    vecs[3] = '{kind: spg_pkg::KIND_PLANE, x: up2.n[0], y: up2.n[1], z: up2.n[2],
                w: off_w, deg: up2.deg, sat: anyc | up2.sat | off_clip};
    vecs[4] = '{kind: spg_pkg::KIND_XUNIT, x: ux2.n[0], y: ux2.n[1], z: ux2.n[2],
                w: 32'd0, deg: ux2.deg, sat: anyc | ux2.sat};
    vecs[5] = '{kind: spg_pkg::KIND_YUNIT, x: uy2.n[0], y: uy2.n[1], z: uy2.n[2],
                w: 32'd0, deg: uy2.deg, sat: anyc | uy2.sat};
  end

  spg_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load_valid (vld[spg_pkg::LAT-1]),
    .vecs       (vecs),
    .out_stall  (out_stall),
    .ready      (ld_ok),
    .out_valid  (out_valid),
    .head       (head)
  );

  assign vector_kind = head.kind;
  assign comp_x      = head.x;
  assign comp_y      = head.y;
  assign comp_z      = head.z;
  assign comp_w      = head.w;
  assign degenerate  = head.deg;
  assign saturated   = head.sat;
  assign last        = (head.kind == spg_pkg::KIND_YUNIT);

  // a full last stage that cannot hand off freezes the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    vld[spg_pkg::LAT-1] && !ld_ok |=> vld == $past(vld))
    else $error("pipeline moved while blocked");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && vector_kind == $past(vector_kind) + 3'd1)
    else $error("vector order broken");

  a_deg: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> vector_kind == spg_pkg::KIND_PLANE
      || vector_kind == spg_pkg::KIND_XUNIT || vector_kind == spg_pkg::KIND_YUNIT)
    else $error("degenerate flag on a corner");

endmodule
